// ----- rtl/core/lss_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lss_pkg
// Shared types, register indexes and a byte case-fold helper for the substring search.
// ----------------------------------------------------------------------------
package lss_pkg;

    // Pattern storage is fixed at 16 bytes by the register map
    localparam int PAT_BYTES   = 16;
    localparam int PAT_IDX_W   = 4;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 64;
    localparam int FIELD_W     = 32;
    localparam int LEN_FIELD_W = 5;

    typedef logic [7:0] byte_t;
    typedef byte_t [PAT_BYTES-1:0] pat_bytes_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LOW  = 8'd0,
        REG_PATTERN_HIGH = 8'd1,
        REG_PATTERN_LEN  = 8'd2,
        REG_IGNORE_CASE  = 8'd3
    } cfg_reg_t;

    localparam byte_t CHAR_UPPER_A = 8'h41;
    localparam byte_t CHAR_UPPER_Z = 8'h5A;
    localparam byte_t CASE_DELTA   = 8'h20;

    // ASCII case fold: only A-Z map to a-z, everything else passes
    function automatic byte_t fold_byte(input byte_t c, input logic ignore_case);
        byte_t r;
        r = c;
        if (ignore_case && (c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) begin
            r = c + CASE_DELTA;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/literal_substring_search.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// literal_substring_search
// Streams text bytes through a window and reports literal pattern matches.
// ----------------------------------------------------------------------------
//  channel   direction  request contents
//  s_        in         text byte (tdata), final byte of text (tlast)
//  m_        out        match start / exclusive match end offsets
//  cfg_      in         register index + 64-bit write data
//
//  One byte per cycle; a request's match is registered and shown the cycle
//  after it is taken. The output register decouples the sides: a new byte is
//  taken whenever the output is empty or being drained in the same cycle.
//  Reset (synchronous, aresetn low) clears window, offset, hold-off and the
//  registers (pattern length back to 1). The configuration port never stalls.
// ----------------------------------------------------------------------------
module literal_substring_search #(
    parameter int MAX_PATTERN = 16,
    parameter int OFFSET_BITS = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // s_tdata: [7:0] text_byte
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,
    input  wire logic        s_tlast,
    // m_tdata: [31:0] first matched byte offset, [63:32] exclusive end offset
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,
    // configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [lss_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lss_pkg::CFG_DATA_W-1:0] cfg_data
);
    import lss_pkg::*;

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;
    localparam int WIDE_W = 64;

    // Configuration registers
    logic [CFG_DATA_W-1:0]  pat_low_reg;
    logic [CFG_DATA_W-1:0]  pat_high_reg;
    logic [LEN_FIELD_W-1:0] pat_len_reg;
    logic                   ignore_case_reg;

    // Stream state
    logic [MAX_PATTERN-1:0][7:0] window_reg, window_next;
    logic [OFFSET_BITS-1:0]      offset_reg, offset_next;
    logic [LEN_W-1:0]            holdoff_reg, holdoff_next;
    logic [LEN_W-1:0]            seen_reg, seen_next;

    // Output register
    logic                 m_valid_reg;
    logic [FIELD_W-1:0]   start_reg, end_reg;

    logic                 s_accept;
    logic [LEN_W-1:0]     eff_len;
    logic                 window_hit;
    logic                 hit;
    logic [OFFSET_BITS-1:0] end_off;
    logic [WIDE_W-1:0]    end_wide, start_wide;
    pat_bytes_t           pattern;

    assign cfg_ready = 1'b1;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign pattern  = {pat_high_reg, pat_low_reg};

    // Effective pattern length clamped to 1..MAX_PATTERN
    always_comb begin
        if (pat_len_reg == '0) begin
            eff_len = LEN_W'(1);
        end else if (pat_len_reg > LEN_FIELD_W'(MAX_PATTERN)) begin
            eff_len = LEN_W'(MAX_PATTERN);
        end else begin
            eff_len = pat_len_reg[LEN_W-1:0];
        end
    end

    // Window shift, newest byte at position 0
    always_comb begin
        window_next[0] = s_tdata;
        for (int k = 1; k < MAX_PATTERN; k++) begin
            window_next[k] = window_reg[k-1];
        end
    end

    // Saturating byte count and end offset
    assign seen_next = (seen_reg < LEN_W'(MAX_PATTERN)) ? seen_reg + LEN_W'(1) : seen_reg;
    assign end_off   = (offset_reg == OFFSET_MAX) ? OFFSET_MAX : offset_reg + OFFSET_BITS'(1);
    assign end_wide  = WIDE_W'(end_off);
    assign start_wide = end_wide - WIDE_W'(eff_len);

    lss_window_match #(
        .MAX_PATTERN (MAX_PATTERN),
        .LEN_W       (LEN_W)
    ) u_match (
        .window      (window_next),
        .pattern     (pattern),
        .pat_len     (eff_len),
        .ignore_case (ignore_case_reg),
        .match       (window_hit)
    );

    assign hit = (holdoff_reg == '0) && (seen_next >= eff_len) && window_hit;

    // Hold-off: count down, or reload with len-2 after a match
    always_comb begin
        if (holdoff_reg != '0) begin
            holdoff_next = holdoff_reg - LEN_W'(1);
        end else if (hit && (eff_len >= LEN_W'(2))) begin
            holdoff_next = eff_len - LEN_W'(2);
        end else begin
            holdoff_next = '0;
        end
    end

    assign offset_next = end_off;

    // Configuration register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_low_reg     <= '0;
            pat_high_reg    <= '0;
            pat_len_reg     <= LEN_FIELD_W'(1);
            ignore_case_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_PATTERN_LOW:  pat_low_reg     <= cfg_data;
                REG_PATTERN_HIGH: pat_high_reg    <= cfg_data;
                REG_PATTERN_LEN:  pat_len_reg     <= cfg_data[LEN_FIELD_W-1:0];
                REG_IGNORE_CASE:  ignore_case_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Stream state; the final byte of a text returns it to reset values
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg  <= '0;
            offset_reg  <= '0;
            holdoff_reg <= '0;
            seen_reg    <= '0;
        end else if (s_accept) begin
            if (s_tlast) begin
                window_reg  <= '0;
                offset_reg  <= '0;
                holdoff_reg <= '0;
                seen_reg    <= '0;
            end else begin
                window_reg  <= window_next;
                offset_reg  <= offset_next;
                holdoff_reg <= holdoff_next;
                seen_reg    <= seen_next;
            end
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= hit;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && hit) begin
            start_reg <= start_wide[FIELD_W-1:0];
            end_reg   <= end_wide[FIELD_W-1:0];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {end_reg, start_reg};

endmodule
`default_nettype wire

// ----- rtl/core/lss_window_match.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lss_window_match
// Parallel compare of the byte window against the active pattern bytes.
// ----------------------------------------------------------------------------
module lss_window_match #(
    parameter int MAX_PATTERN = 16,
    parameter int LEN_W       = 5
) (
    input  wire logic [MAX_PATTERN-1:0][7:0] window,
    input  wire lss_pkg::pat_bytes_t         pattern,
    input  wire logic [LEN_W-1:0]            pat_len,
    input  wire logic                        ignore_case,
    output logic                             match
);
    import lss_pkg::*;

    logic [MAX_PATTERN-1:0] lane_ok;

    // Window position k (newest at 0) must equal pattern byte len-1-k
    always_comb begin
        logic [LEN_W:0]       diff;
        logic [PAT_IDX_W-1:0] idx;
        for (int k = 0; k < MAX_PATTERN; k++) begin
            diff = {1'b0, pat_len} - (LEN_W+1)'(k + 1);
            idx  = diff[PAT_IDX_W-1:0];
            if ((LEN_W+1)'(k) < {1'b0, pat_len}) begin
                lane_ok[k] = fold_byte(window[k], ignore_case)
                          == fold_byte(pattern[idx], ignore_case);
            end else begin
                lane_ok[k] = 1'b1;
            end
        end
    end

    assign match = &lane_ok;

endmodule
`default_nettype wire
